/* hdl/pfc_pkg.sv */
// Shared types, constants and table geometry helpers for the Playfair digraph cipher.
package pfc_pkg;

    localparam int ROWS     = 7;
    localparam int COLUMNS  = 10;
    localparam int SYMBOLS  = 70;
    localparam int SYM_W    = 7;
    localparam int IDX_W    = $clog2(SYMBOLS);
    localparam int FILL_W   = $clog2(SYMBOLS + 1);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int FILLER_X = (34 < SYMBOLS) ? 34 : 0;

    typedef enum logic [2:0] {
        MODE_KEY_START  = 3'd0,
        MODE_KEY_SYMBOL = 3'd1,
        MODE_KEY_FINISH = 3'd2,
        MODE_ENCODE     = 3'd3,
        MODE_DECODE     = 3'd4
    } pfc_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK,
        ST_PUSH,
        ST_RDA,
        ST_RDB,
        ST_CELLA,
        ST_CELLB,
        ST_EMITA,
        ST_EMITB,
        ST_TAIL,
        ST_FLUSH
    } pfc_state_t;

    typedef struct packed {
        logic [2:0]       mode;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } pfc_cmd_t;

    typedef struct packed {
        logic [SYM_W-1:0] out_symbol;
        logic             is_empty;
        logic             end_of_text;
    } pfc_res_t;

    function automatic logic [ROW_W-1:0] row_of(input logic [IDX_W-1:0] p);
        logic [ROW_W-1:0] r;
        r = '0;
        for (int k = 1; k < ROWS; k++) begin
            if (p >= IDX_W'(k * COLUMNS)) begin
                r = ROW_W'(k);
            end
        end
        return r;
    endfunction

    function automatic logic [COL_W-1:0] col_of(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] base;
        base = IDX_W'(row_of(p) * COLUMNS);
        return COL_W'(p - base);
    endfunction

    function automatic logic [COL_W-1:0] step_col(input logic [COL_W-1:0] c,
                                                  input logic dec);
        logic [COL_W-1:0] r;
        if (dec) begin
            r = (c == '0) ? COL_W'(COLUMNS - 1) : COL_W'(c - 1'b1);
        end else begin
            r = (c == COL_W'(COLUMNS - 1)) ? '0 : COL_W'(c + 1'b1);
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] step_row(input logic [ROW_W-1:0] r,
                                                  input logic dec);
        logic [ROW_W-1:0] q;
        if (dec) begin
            q = (r == '0) ? ROW_W'(ROWS - 1) : ROW_W'(r - 1'b1);
        end else begin
            q = (r == ROW_W'(ROWS - 1)) ? '0 : ROW_W'(r + 1'b1);
        end
        return q;
    endfunction

    function automatic logic [IDX_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        logic [IDX_W:0] s;
        s = (IDX_W + 1)'(r * COLUMNS) + (IDX_W + 1)'(c);
        if (s >= (IDX_W + 1)'(SYMBOLS)) begin
            s = s - (IDX_W + 1)'(SYMBOLS);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

/* hdl/pfc_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module pfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/playfair_digraph_cipher_core.sv */
// Playfair digraph cipher core: key table and place memories with a pair sequencer.
// Key start and key symbol words complete in the idle state; key finish walks the alphabet in ST_WALK.
// Encode and decode words run through the push, tail and flush states: each completed pair
// adds two place reads and two table reads on one read port per memory, and two emits.
// Results leave through a one-word output register after a one-word pending stage.
// Reset (rst_n, asynchronous) gives the identity key and drop_filler_x set; no clearing pass.
module playfair_digraph_cipher_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  pfc_pkg::pfc_cmd_t cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output pfc_pkg::pfc_res_t res,
    input  logic             cfg_we,
    input  logic             cfg_data
);

    localparam int IW = pfc_pkg::IDX_W;
    localparam int SW = pfc_pkg::SYM_W;

    pfc_pkg::pfc_state_t state_reg, state_next;
    pfc_pkg::pfc_cmd_t   cmd_reg, cmd_next;
    pfc_pkg::pfc_res_t   res_reg, res_next;
    logic                res_valid_reg, res_valid_next;
    logic [SW-1:0]       pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;

    logic [pfc_pkg::SYMBOLS-1:0] used_reg, used_next;
    logic [pfc_pkg::SYMBOLS-1:0] kt_ok_reg, kt_ok_next;
    logic [pfc_pkg::SYMBOLS-1:0] sp_ok_reg, sp_ok_next;
    logic [pfc_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic [IW-1:0]               walk_reg, walk_next;

    logic [SW-1:0] held_reg, held_next;
    logic          held_valid_reg, held_valid_next;
    logic [SW-1:0] prev_reg, prev_next;
    logic [SW-1:0] win0_reg, win0_next;
    logic [SW-1:0] win1_reg, win1_next;
    logic [1:0]    wcnt_reg, wcnt_next;
    logic          drop_reg, drop_next;
    logic          fx_first_reg, fx_first_next;
    logic [1:0]    pidx_reg, pidx_next;
    logic [SW-1:0] b_reg, b_next;
    logic [IW-1:0] pa_reg, pa_next;
    logic [IW-1:0] ia_reg, ia_next;
    logic [IW-1:0] ib_reg, ib_next;
    logic [SW-1:0] oa_reg, oa_next;
    logic [SW-1:0] ob_reg, ob_next;

    logic          cmd_accept;
    logic          out_free;
    logic          can_emit;
    logic          emit_go;
    logic [SW-1:0] emit_val;
    logic          place_en;
    logic [SW-1:0] place_sym;
    logic          kt_we;
    logic          sp_we;
    logic [IW-1:0] kt_waddr;
    logic [IW-1:0] sp_waddr;
    logic [IW-1:0] kt_raddr;
    logic [IW-1:0] sp_raddr;
    logic [SW-1:0] kt_rdata;
    logic [IW-1:0] sp_rdata;

    logic          is_dec;
    logic          p_act;
    logic [SW-1:0] p_sym;
    logic          held_placed;
    logic          p_placed;
    logic [IW-1:0] pb;
    logic [pfc_pkg::ROW_W-1:0] ra, rb;
    logic [pfc_pkg::COL_W-1:0] ca, cb;
    logic [SW-1:0] d_sym;
    logic          win_emit;

    assign cmd_stall  = (state_reg != pfc_pkg::ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign is_dec     = (cmd_reg.mode == pfc_pkg::MODE_DECODE);

    pfc_ram #(.WIDTH(SW), .DEPTH(pfc_pkg::SYMBOLS)) u_key_table (
        .clk   (clk),
        .we    (kt_we),
        .waddr (kt_waddr),
        .wdata (place_sym),
        .raddr (kt_raddr),
        .rdata (kt_rdata)
    );

    pfc_ram #(.WIDTH(IW), .DEPTH(pfc_pkg::SYMBOLS)) u_symbol_place (
        .clk   (clk),
        .we    (sp_we),
        .waddr (sp_waddr),
        .wdata (fill_reg[IW-1:0]),
        .raddr (sp_raddr),
        .rdata (sp_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        used_next       = used_reg;
        kt_ok_next      = kt_ok_reg;
        sp_ok_next      = sp_ok_reg;
        fill_next       = fill_reg;
        walk_next       = walk_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        prev_next       = prev_reg;
        win0_next       = win0_reg;
        win1_next       = win1_reg;
        wcnt_next       = wcnt_reg;
        drop_next       = cfg_we ? cfg_data : drop_reg;
        fx_first_next   = fx_first_reg;
        pidx_next       = pidx_reg;
        b_next          = b_reg;
        pa_next         = pa_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        oa_next         = oa_reg;
        ob_next         = ob_reg;

        out_free  = !res_valid_reg || !res_stall;
        can_emit  = !pend_valid_reg || out_free;
        emit_go   = 1'b0;
        emit_val  = '0;
        place_en  = 1'b0;
        place_sym = cmd.symbol;
        kt_we     = 1'b0;
        sp_we     = 1'b0;
        kt_waddr  = fill_reg[IW-1:0];
        sp_waddr  = '0;
        kt_raddr  = '0;
        sp_raddr  = '0;
        p_act     = 1'b0;
        p_sym     = cmd_reg.symbol;
        held_placed = 1'b0;
        p_placed  = 1'b0;
        pb        = '0;
        ra        = '0;
        rb        = '0;
        ca        = '0;
        cb        = '0;
        d_sym     = oa_reg;
        win_emit  = 1'b0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    cmd_next  = cmd;
                    pidx_next = '0;
                    unique case (cmd.mode)
                        pfc_pkg::MODE_KEY_START:
                        begin
                            used_next       = '0;
                            fill_next       = '0;
                            held_next       = '0;
                            held_valid_next = 1'b0;
                            prev_next       = SW'(pfc_pkg::SYMBOLS);
                            win0_next       = '0;
                            win1_next       = '0;
                            wcnt_next       = '0;
                        end
                        pfc_pkg::MODE_KEY_SYMBOL:
                        begin
                            place_en = 1'b1;
                        end
                        pfc_pkg::MODE_KEY_FINISH:
                        begin
                            walk_next  = '0;
                            state_next = pfc_pkg::ST_WALK;
                        end
                        pfc_pkg::MODE_ENCODE:
                        begin
                            fx_first_next = (prev_reg < SW'(pfc_pkg::SYMBOLS))
                                            && (prev_reg == cmd.symbol);
                            prev_next     = cmd.symbol;
                            wcnt_next     = '0;
                            state_next    = pfc_pkg::ST_PUSH;
                        end
                        pfc_pkg::MODE_DECODE:
                        begin
                            state_next = pfc_pkg::ST_PUSH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pfc_pkg::ST_WALK:
            begin
                place_en  = 1'b1;
                place_sym = SW'(walk_reg);
                walk_next = IW'(walk_reg + 1'b1);
                if (walk_reg == IW'(pfc_pkg::SYMBOLS - 1))
                begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_PUSH:
            begin
                unique case (pidx_reg)
                    2'd0:
                    begin
                        p_act = !is_dec && fx_first_reg;
                        p_sym = SW'(pfc_pkg::FILLER_X);
                    end
                    2'd1:
                    begin
                        p_act = is_dec || (cmd_reg.symbol < SW'(pfc_pkg::SYMBOLS));
                        p_sym = cmd_reg.symbol;
                    end
                    2'd2:
                    begin
                        p_act = !is_dec && cmd_reg.last && held_valid_reg;
                        p_sym = SW'(pfc_pkg::FILLER_X);
                    end
                    default:
                    begin
                        p_act = 1'b0;
                        p_sym = cmd_reg.symbol;
                    end
                endcase
                held_placed = (held_reg < SW'(pfc_pkg::SYMBOLS))
                              && used_reg[held_reg[IW-1:0]];
                p_placed    = (p_sym < SW'(pfc_pkg::SYMBOLS))
                              && used_reg[p_sym[IW-1:0]];
                if (pidx_reg == 2'd3)
                begin
                    state_next = pfc_pkg::ST_TAIL;
                end
                else if (!p_act)
                begin
                    pidx_next = pidx_reg + 2'd1;
                end
                else if (!held_valid_reg)
                begin
                    held_next       = p_sym;
                    held_valid_next = 1'b1;
                    pidx_next       = pidx_reg + 2'd1;
                end
                else
                begin
                    held_valid_next = 1'b0;
                    if (held_placed && p_placed)
                    begin
                        b_next     = p_sym;
                        sp_raddr   = held_reg[IW-1:0];
                        state_next = pfc_pkg::ST_RDA;
                    end
                    else
                    begin
                        pidx_next = pidx_reg + 2'd1;
                    end
                end
            end
            pfc_pkg::ST_RDA:
            begin
                pa_next    = sp_ok_reg[held_reg[IW-1:0]] ? sp_rdata : held_reg[IW-1:0];
                sp_raddr   = b_reg[IW-1:0];
                state_next = pfc_pkg::ST_RDB;
            end
            pfc_pkg::ST_RDB:
            begin
                pb = sp_ok_reg[b_reg[IW-1:0]] ? sp_rdata : b_reg[IW-1:0];
                ra = pfc_pkg::row_of(pa_reg);
                ca = pfc_pkg::col_of(pa_reg);
                rb = pfc_pkg::row_of(pb);
                cb = pfc_pkg::col_of(pb);
                if (ra == rb)
                begin
                    ia_next = pfc_pkg::cell_idx(ra, pfc_pkg::step_col(ca, is_dec));
                    ib_next = pfc_pkg::cell_idx(rb, pfc_pkg::step_col(cb, is_dec));
                end
                else if (ca == cb)
                begin
                    ia_next = pfc_pkg::cell_idx(pfc_pkg::step_row(ra, is_dec), ca);
                    ib_next = pfc_pkg::cell_idx(pfc_pkg::step_row(rb, is_dec), cb);
                end
                else
                begin
                    ia_next = pfc_pkg::cell_idx(ra, cb);
                    ib_next = pfc_pkg::cell_idx(rb, ca);
                end
                kt_raddr   = ia_next;
                state_next = pfc_pkg::ST_CELLA;
            end
            pfc_pkg::ST_CELLA:
            begin
                oa_next    = kt_ok_reg[ia_reg] ? kt_rdata : SW'(ia_reg);
                kt_raddr   = ib_reg;
                state_next = pfc_pkg::ST_CELLB;
            end
            pfc_pkg::ST_CELLB:
            begin
                ob_next    = kt_ok_reg[ib_reg] ? kt_rdata : SW'(ib_reg);
                state_next = pfc_pkg::ST_EMITA;
            end
            pfc_pkg::ST_EMITA, pfc_pkg::ST_EMITB:
            begin
                d_sym = (state_reg == pfc_pkg::ST_EMITA) ? oa_reg : ob_reg;
                if (is_dec)
                begin
                    win_emit = (wcnt_reg == 2'd1)
                               || ((wcnt_reg == 2'd2)
                                   && !(drop_reg
                                        && (win1_reg == SW'(pfc_pkg::FILLER_X))
                                        && (win0_reg == d_sym)));
                    emit_val = win1_reg;
                end
                else
                begin
                    win_emit = 1'b1;
                    emit_val = d_sym;
                end
                if (!win_emit || can_emit)
                begin
                    emit_go = win_emit;
                    if (is_dec)
                    begin
                        win1_next = d_sym;
                        if (wcnt_reg == 2'd0)
                        begin
                            wcnt_next = 2'd1;
                        end
                        else
                        begin
                            win0_next = win1_reg;
                            wcnt_next = 2'd2;
                        end
                    end
                    if (state_reg == pfc_pkg::ST_EMITA)
                    begin
                        state_next = pfc_pkg::ST_EMITB;
                    end
                    else
                    begin
                        pidx_next  = pidx_reg + 2'd1;
                        state_next = pfc_pkg::ST_PUSH;
                    end
                end
            end
            pfc_pkg::ST_TAIL:
            begin
                if (is_dec && cmd_reg.last)
                begin
                    held_valid_next = 1'b0;
                    emit_val        = win1_reg;
                    if (wcnt_reg == 2'd0)
                    begin
                        state_next = pfc_pkg::ST_FLUSH;
                    end
                    else if (can_emit)
                    begin
                        emit_go    = 1'b1;
                        state_next = pfc_pkg::ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = pfc_pkg::ST_FLUSH;
                end
            end
            pfc_pkg::ST_FLUSH:
            begin
                if (cmd_reg.last)
                begin
                    if (out_free)
                    begin
                        res_next.out_symbol  = pend_valid_reg ? pend_reg : '0;
                        res_next.is_empty    = !pend_valid_reg;
                        res_next.end_of_text = 1'b1;
                        res_valid_next       = 1'b1;
                        pend_valid_next      = 1'b0;
                        held_next            = '0;
                        held_valid_next      = 1'b0;
                        prev_next            = SW'(pfc_pkg::SYMBOLS);
                        win0_next            = '0;
                        win1_next            = '0;
                        wcnt_next            = '0;
                        state_next           = pfc_pkg::ST_IDLE;
                    end
                end
                else if (!pend_valid_reg)
                begin
                    state_next = pfc_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    res_next.out_symbol  = pend_reg;
                    res_next.is_empty    = 1'b0;
                    res_next.end_of_text = 1'b0;
                    res_valid_next       = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = pfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase

        if (emit_go)
        begin
            if (pend_valid_reg)
            begin
                res_next.out_symbol  = pend_reg;
                res_next.is_empty    = 1'b0;
                res_next.end_of_text = 1'b0;
                res_valid_next       = 1'b1;
            end
            pend_next       = emit_val;
            pend_valid_next = 1'b1;
        end

        if (place_en && (place_sym < SW'(pfc_pkg::SYMBOLS))
            && (fill_reg < pfc_pkg::FILL_W'(pfc_pkg::SYMBOLS)))
        begin
            if (!used_reg[place_sym[IW-1:0]])
            begin
                kt_we                         = 1'b1;
                sp_we                         = 1'b1;
                sp_waddr                      = place_sym[IW-1:0];
                used_next[place_sym[IW-1:0]]  = 1'b1;
                sp_ok_next[place_sym[IW-1:0]] = 1'b1;
                kt_ok_next[fill_reg[IW-1:0]]  = 1'b1;
                fill_next                     = pfc_pkg::FILL_W'(fill_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pfc_pkg::ST_IDLE;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            used_reg       <= '1;
            kt_ok_reg      <= '0;
            sp_ok_reg      <= '0;
            fill_reg       <= pfc_pkg::FILL_W'(pfc_pkg::SYMBOLS);
            walk_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            prev_reg       <= SW'(pfc_pkg::SYMBOLS);
            win0_reg       <= '0;
            win1_reg       <= '0;
            wcnt_reg       <= '0;
            drop_reg       <= 1'b1;
            fx_first_reg   <= 1'b0;
            pidx_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
            used_reg       <= used_next;
            kt_ok_reg      <= kt_ok_next;
            sp_ok_reg      <= sp_ok_next;
            fill_reg       <= fill_next;
            walk_reg       <= walk_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            prev_reg       <= prev_next;
            win0_reg       <= win0_next;
            win1_reg       <= win1_next;
            wcnt_reg       <= wcnt_next;
            drop_reg       <= drop_next;
            fx_first_reg   <= fx_first_next;
            pidx_reg       <= pidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
        pend_reg <= pend_next;
        b_reg    <= b_next;
        pa_reg   <= pa_next;
        ia_reg   <= ia_next;
        ib_reg   <= ib_next;
        oa_reg   <= oa_next;
        ob_reg   <= ob_next;
    end

endmodule

/* hdl/pfc_checker.sv */
// Port-level checker for the Playfair digraph cipher core and its bind.
module pfc_port_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input pfc_pkg::pfc_cmd_t cmd,
    input logic              res_valid,
    input logic              res_stall,
    input pfc_pkg::pfc_res_t res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result word changed while stalled");

    a_empty_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.is_empty |-> res.end_of_text && (res.out_symbol == '0))
        else $error("empty word does not close a text");

    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.is_empty |-> res.out_symbol < pfc_pkg::SYM_W'(pfc_pkg::SYMBOLS))
        else $error("result symbol outside alphabet");

    a_finish_walks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall && (cmd.mode == pfc_pkg::MODE_KEY_FINISH)
        |=> cmd_stall)
        else $error("key finish word did not start the table walk");

endmodule

bind playfair_digraph_cipher_core pfc_port_checker u_pfc_port_checker (.*);

/* verif/pfc_checker.sv */
// Checker for the Playfair core: watches both channels, predicts results and compares them.
module pfc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  pfc_pkg::pfc_cmd_t cmd,
    input  logic              res_valid,
    input  logic              res_stall,
    input  pfc_pkg::pfc_res_t res,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [6:0]        key_tab [pfc_pkg::SYMBOLS];
    logic [6:0]        place_of [pfc_pkg::SYMBOLS];
    bit                in_table [pfc_pkg::SYMBOLS];
    int                filled;
    logic [6:0]        held;
    bit                held_ok;
    logic [6:0]        prev_raw;
    logic [6:0]        win [2];
    int                win_n;
    bit                text_start;
    bit                drop_x;
    pfc_pkg::pfc_res_t expected_words [$];
    pfc_pkg::pfc_res_t batch [$];

    assign pending_count = expected_words.size();

    function automatic void clear_text();
        held = '0;
        held_ok = 1'b0;
        prev_raw = 7'(pfc_pkg::SYMBOLS);
        win[0] = '0;
        win[1] = '0;
        win_n = 0;
        text_start = 1'b1;
    endfunction

    function automatic void put(logic [6:0] s, bit empty);
        pfc_pkg::pfc_res_t r;
        if (batch.size() >= 4)
            return;
        r.out_symbol = empty ? 7'd0 : s;
        r.is_empty = empty;
        r.end_of_text = 1'b0;
        batch.push_back(r);
    endfunction

    function automatic bit is_placed(int s);
        return s < pfc_pkg::SYMBOLS && in_table[s];
    endfunction

    function automatic int cell_at(int r, int c);
        return key_tab[((r % pfc_pkg::ROWS) * pfc_pkg::COLUMNS + (c % pfc_pkg::COLUMNS))
                       % pfc_pkg::SYMBOLS];
    endfunction

    function automatic void window_in(int d);
        if (win_n == 0)
        begin
            win[1] = 7'(d);
            win_n = 1;
            return;
        end
        if (win_n == 1)
        begin
            put(win[1], 1'b0);
            win_n = 2;
        end
        else if (!(drop_x && win[1] == 7'(pfc_pkg::FILLER_X) && win[0] == 7'(d)))
            put(win[1], 1'b0);
        win[0] = win[1];
        win[1] = 7'(d);
    endfunction

    function automatic void pair_in(int s, bit dec);
        int pa, pb, ra, ca, rb, cb, oa, ob, st;
        if (!held_ok)
        begin
            held = 7'(s);
            held_ok = 1'b1;
            return;
        end
        held_ok = 1'b0;
        if (!is_placed(held) || !is_placed(s))
            return;
        pa = place_of[held];
        pb = place_of[s];
        ra = (pa / pfc_pkg::COLUMNS) % pfc_pkg::ROWS;
        ca = pa % pfc_pkg::COLUMNS;
        rb = (pb / pfc_pkg::COLUMNS) % pfc_pkg::ROWS;
        cb = pb % pfc_pkg::COLUMNS;
        if (ra == rb)
        begin
            st = dec ? pfc_pkg::COLUMNS - 1 : 1;
            oa = cell_at(ra, ca + st);
            ob = cell_at(rb, cb + st);
        end
        else if (ca == cb)
        begin
            st = dec ? pfc_pkg::ROWS - 1 : 1;
            oa = cell_at(ra + st, ca);
            ob = cell_at(rb + st, cb);
        end
        else
        begin
            oa = cell_at(ra, cb);
            ob = cell_at(rb, ca);
        end
        if (dec)
        begin
            window_in(oa);
            window_in(ob);
        end
        else
        begin
            put(7'(oa), 1'b0);
            put(7'(ob), 1'b0);
        end
    endfunction

    function automatic void add_key(int s);
        if (s < pfc_pkg::SYMBOLS && !in_table[s] && filled < pfc_pkg::SYMBOLS)
        begin
            key_tab[filled] = 7'(s);
            place_of[s] = 7'(filled);
            in_table[s] = 1'b1;
            filled++;
        end
    endfunction

    function automatic void cipher_word(pfc_pkg::pfc_cmd_t w);
        int s;
        s = w.symbol;
        batch.delete();
        case (w.mode)
            pfc_pkg::MODE_KEY_START:
            begin
                foreach (in_table[i]) in_table[i] = 1'b0;
                filled = 0;
                clear_text();
                return;
            end
            pfc_pkg::MODE_KEY_SYMBOL:
            begin
                add_key(s);
                return;
            end
            pfc_pkg::MODE_KEY_FINISH:
            begin
                for (int i = 0; i < pfc_pkg::SYMBOLS; i++) add_key(i);
                return;
            end
            pfc_pkg::MODE_ENCODE, pfc_pkg::MODE_DECODE: ;
            default: return;
        endcase
        if (text_start)
        begin
            clear_text();
            text_start = 1'b0;
        end
        if (w.mode == pfc_pkg::MODE_ENCODE)
        begin
            win_n = 0;
            if (prev_raw < 7'(pfc_pkg::SYMBOLS) && prev_raw == 7'(s))
                pair_in(pfc_pkg::FILLER_X, 1'b0);
            if (s < pfc_pkg::SYMBOLS)
                pair_in(s, 1'b0);
            prev_raw = 7'(s);
            if (w.last && held_ok)
                pair_in(pfc_pkg::FILLER_X, 1'b0);
        end
        else
        begin
            pair_in(s, 1'b1);
            if (w.last)
            begin
                held_ok = 1'b0;
                if (win_n >= 1)
                    put(win[1], 1'b0);
            end
        end
        if (w.last)
        begin
            if (batch.size() == 0)
                put('0, 1'b1);
            batch[batch.size() - 1].end_of_text = 1'b1;
            clear_text();
        end
        foreach (batch[i]) expected_words.push_back(batch[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pfc_pkg::pfc_res_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < pfc_pkg::SYMBOLS; i++)
            begin
                key_tab[i] = 7'(i);
                place_of[i] = 7'(i);
                in_table[i] = 1'b1;
            end
            filled = pfc_pkg::SYMBOLS;
            drop_x = 1'b1;
            clear_text();
            expected_words.delete();
            fail_count = 0;
            result_count = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                result_count++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word %p", res);
                    fail_count++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (res.out_symbol !== e.out_symbol)
                    begin
                        $error("out_symbol: expected %0d, got %0d", e.out_symbol,
                               res.out_symbol);
                        fail_count++;
                    end
                    if (res.is_empty !== e.is_empty)
                    begin
                        $error("is_empty: expected %0d, got %0d", e.is_empty, res.is_empty);
                        fail_count++;
                    end
                    if (res.end_of_text !== e.end_of_text)
                    begin
                        $error("end_of_text: expected %0d, got %0d", e.end_of_text,
                               res.end_of_text);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                drop_x = cfg_data;
            if (cmd_valid && !cmd_stall)
                cipher_word(cmd);
        end
    end
endmodule

/* verif/tb_playfair_digraph_cipher_core.sv */
// Testbench top for the Playfair core: reset, stimulus, idling, watchdog and verdict.
module tb_playfair_digraph_cipher_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    pfc_pkg::pfc_cmd_t cmd = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    pfc_pkg::pfc_res_t res;
    logic              cfg_we = 1'b0;
    logic              cfg_data = 1'b0;
    int                fail_count, pending_count, result_count;
    int                idle_cycles = 0;
    int                word_count = 0;
    int                stall_mode = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    playfair_digraph_cipher_core DUT (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    pfc_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
        .res_valid(res_valid), .res_stall(res_stall), .res(res),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                default: res_stall <= ($urandom_range(0, 3) != 0);
            endcase
            if ($urandom_range(0, 60) == 0)
                stall_mode <= int'($urandom_range(0, 2));
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send(pfc_pkg::pfc_mode_t m, int s, bit lst);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(0, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_valid <= 1'b1;
        cmd <= '{mode: m, symbol: 7'(s), last: lst};
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        word_count++;
        if (burst_left == 0)
            cmd_valid <= 1'b0;
    endtask

    task automatic send_raw(logic [2:0] m, int s, bit lst);
        send(pfc_pkg::pfc_mode_t'(m), s, lst);
    endtask

    task automatic settle();
        cmd_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_drop(bit v);
        settle();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_key(int n);
        send(pfc_pkg::MODE_KEY_START, 0, 1'b0);
        repeat (n) send(pfc_pkg::MODE_KEY_SYMBOL, $urandom_range(0, 127), 1'b0);
        send(pfc_pkg::MODE_KEY_FINISH, 0, 1'b0);
    endtask

    task automatic random_text(bit dec);
        int len;
        int s;
        len = $urandom_range(1, 9);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0: s = $urandom_range(70, 127);
                1, 2: s = pfc_pkg::FILLER_X;
                3: s = $urandom_range(0, 3);
                default: s = $urandom_range(0, 69);
            endcase
            if ($urandom_range(0, 12) == 0)
                send_raw(3'($urandom_range(0, 7)), s, i == len - 1);
            else
                send(dec ? pfc_pkg::MODE_DECODE : pfc_pkg::MODE_ENCODE, s, i == len - 1);
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(pfc_pkg::MODE_ENCODE, 0, 1'b0);
        send(pfc_pkg::MODE_ENCODE, 0, 1'b0);
        send(pfc_pkg::MODE_ENCODE, 127, 1'b0);
        send(pfc_pkg::MODE_ENCODE, 69, 1'b1);
        send(pfc_pkg::MODE_ENCODE, 5, 1'b1);
        send(pfc_pkg::MODE_ENCODE, 70, 1'b1);
        send(pfc_pkg::MODE_DECODE, 7, 1'b0);
        send(pfc_pkg::MODE_DECODE, 34, 1'b0);
        send(pfc_pkg::MODE_DECODE, 7, 1'b0);
        send(pfc_pkg::MODE_DECODE, 34, 1'b0);
        send(pfc_pkg::MODE_DECODE, 3, 1'b1);
        send(pfc_pkg::MODE_DECODE, 70, 1'b0);
        send(pfc_pkg::MODE_DECODE, 12, 1'b1);
        send_raw(3'd5, 1, 1'b1);
        send_raw(3'd7, 2, 1'b0);
        send(pfc_pkg::MODE_KEY_FINISH, 0, 1'b0);
        send(pfc_pkg::MODE_KEY_START, 0, 1'b0);
        send(pfc_pkg::MODE_KEY_SYMBOL, 42, 1'b0);
        send(pfc_pkg::MODE_KEY_SYMBOL, 42, 1'b0);
        send(pfc_pkg::MODE_ENCODE, 42, 1'b0);
        send(pfc_pkg::MODE_ENCODE, 1, 1'b1);
        send(pfc_pkg::MODE_KEY_SYMBOL, 120, 1'b0);
        send(pfc_pkg::MODE_KEY_FINISH, 0, 1'b0);
        send(pfc_pkg::MODE_KEY_SYMBOL, 3, 1'b0);
        write_drop(1'b0);
        send(pfc_pkg::MODE_DECODE, 7, 1'b0);
        send(pfc_pkg::MODE_DECODE, 34, 1'b0);
        send(pfc_pkg::MODE_DECODE, 7, 1'b0);
        send(pfc_pkg::MODE_DECODE, 34, 1'b1);
        for (int phase = 0; phase < 6; phase++)
        begin
            write_drop(1'(phase % 2));
            load_key($urandom_range(0, 25));
            while (word_count < 30 + (phase + 1) * 42)
                random_text(1'($urandom_range(0, 1)));
        end
        send(pfc_pkg::MODE_KEY_START, 0, 1'b0);
        for (int i = 0; i < 70; i++) send(pfc_pkg::MODE_KEY_SYMBOL, 69 - i, 1'b0);
        send(pfc_pkg::MODE_KEY_SYMBOL, 5, 1'b0);
        send(pfc_pkg::MODE_KEY_FINISH, 0, 1'b0);
        repeat (3) random_text(1'b1);
        settle();
        $display("sent %0d command words, checked %0d result words", word_count,
                 result_count);
        $display("covered key loads, encode/decode with both filler settings");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
